// ----- sv/gear_estimator_shift_rpm_assert.svh -----
// ----------------------------------------------------------------------------
// Gear estimator assertion macros
// Concurrent property shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef GEAR_ESTIMATOR_SHIFT_RPM_ASSERT_SVH
`define GEAR_ESTIMATOR_SHIFT_RPM_ASSERT_SVH

// same-cycle implication
`define GESR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gear estimator assertion failed");

// next-cycle implication
`define GESR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gear estimator assertion failed");

`endif

// ----- sv/gesr_pkg.sv -----
// ----------------------------------------------------------------------------
// Gear estimator package
// Widths, register indexes, microcode fields and the control store.
// ----------------------------------------------------------------------------
`default_nettype none

package gesr_pkg;

   localparam int RPM_W       = 14;
   localparam int SPEED_W     = 8;
   localparam int GEAR_W      = 3;
   localparam int SHIFT_W     = 16;
   localparam int RATIO_W     = 16;
   localparam int WRS_W       = 20;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 40;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;

   localparam int MUL_A_W     = 16;
   localparam int MUL_B_W     = 52;
   localparam int PROD_W      = 68;
   localparam int WHEEL_W     = 28;
   localparam int DRIVE_W     = 44;
   localparam int DRIVE_PCT_W = 51;
   localparam int FRAC_W      = 36;
   localparam int LIM_W       = 21;
   localparam int HI_W        = PROD_W - FRAC_W;
   localparam int RATIO_COUNT = 6;

   localparam logic [MUL_A_W-1:0] PCT_SCALE = 16'd100;
   localparam logic [LIM_W-1:0]   PCT_LO    = 21'd87;
   localparam logic [LIM_W-1:0]   PCT_HI    = 21'd113;
   localparam logic [GEAR_W-1:0]  HELD_RESET = 3'd3;
   localparam logic [GEAR_W-1:0]  GEAR_NONE  = 3'd0;

   localparam logic [CSR_INDEX_W-1:0] CSR_RATIO_FIRST  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATIO_SECOND = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATIO_THIRD  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATIO_FOURTH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATIO_FIFTH  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATIO_SIXTH  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_FINAL_DRIVE  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_WHEEL        = 3'd7;

   typedef enum logic [3:0] {
      STEP_IDLE,
      STEP_WHEEL,
      STEP_DRIVE,
      STEP_SCALE,
      STEP_GEAR_MUL,
      STEP_GEAR_TEST,
      STEP_HOLD,
      STEP_UP_MUL,
      STEP_DOWN_MUL,
      STEP_EMIT
   } step_type;

   typedef enum logic [2:0] {
      ASEL_NONE,
      ASEL_SPEED,
      ASEL_FINAL,
      ASEL_SCALE,
      ASEL_RATIO_LOOP,
      ASEL_RATIO_UP,
      ASEL_RATIO_DOWN
   } a_sel_type;

   typedef enum logic [1:0] {
      BSEL_WHEEL_CFG,
      BSEL_WHEEL,
      BSEL_DRIVE,
      BSEL_DRIVE_PCT
   } b_sel_type;

   typedef enum logic [2:0] {
      DST_NONE,
      DST_WHEEL,
      DST_DRIVE,
      DST_DRIVE_PCT,
      DST_PROD
   } dst_type;

   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_WAIT,
      JMP_LOOP,
      JMP_EMIT
   } jmp_type;

   typedef struct packed {
      a_sel_type a_sel;
      b_sel_type b_sel;
      dst_type   dst;
      logic      test;
      logic      hold_upd;
      logic      up_ld;
      logic      emit;
      logic      loop_clr;
      logic      cnt_inc;
      jmp_type   jmp;
      step_type  target;
   } ctl_type;

   localparam ctl_type CTL_NOP = '{
      a_sel:    ASEL_NONE,
      b_sel:    BSEL_WHEEL_CFG,
      dst:      DST_NONE,
      test:     1'b0,
      hold_upd: 1'b0,
      up_ld:    1'b0,
      emit:     1'b0,
      loop_clr: 1'b0,
      cnt_inc:  1'b0,
      jmp:      JMP_NEXT,
      target:   STEP_IDLE
   };

   function automatic ctl_type ctl_rom(step_type s);
      ctl_type c;
      c = CTL_NOP;
      case (s)
         STEP_IDLE: begin
            c.loop_clr = 1'b1;
            c.jmp      = JMP_WAIT;
         end
         STEP_WHEEL: begin
            c.a_sel = ASEL_SPEED;
            c.b_sel = BSEL_WHEEL_CFG;
            c.dst   = DST_WHEEL;
         end
         STEP_DRIVE: begin
            c.a_sel = ASEL_FINAL;
            c.b_sel = BSEL_WHEEL;
            c.dst   = DST_DRIVE;
         end
         STEP_SCALE: begin
            c.a_sel = ASEL_SCALE;
            c.b_sel = BSEL_DRIVE;
            c.dst   = DST_DRIVE_PCT;
         end
         STEP_GEAR_MUL: begin
            c.a_sel = ASEL_RATIO_LOOP;
            c.b_sel = BSEL_DRIVE_PCT;
            c.dst   = DST_PROD;
         end
         STEP_GEAR_TEST: begin
            c.test    = 1'b1;
            c.cnt_inc = 1'b1;
            c.jmp     = JMP_LOOP;
            c.target  = STEP_GEAR_MUL;
         end
         STEP_HOLD: begin
            c.hold_upd = 1'b1;
         end
         STEP_UP_MUL: begin
            c.a_sel = ASEL_RATIO_UP;
            c.b_sel = BSEL_DRIVE;
            c.dst   = DST_PROD;
         end
         STEP_DOWN_MUL: begin
            c.up_ld = 1'b1;
            c.a_sel = ASEL_RATIO_DOWN;
            c.b_sel = BSEL_DRIVE;
            c.dst   = DST_PROD;
         end
         STEP_EMIT: begin
            c.emit   = 1'b1;
            c.jmp    = JMP_EMIT;
            c.target = STEP_IDLE;
         end
         default: begin
            c.jmp    = JMP_EMIT;
            c.target = STEP_IDLE;
         end
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- sv/gear_estimator_shift_rpm.sv -----
// A request beat is taken only in the idle step; the single shared 16x52 multiplier
// then steps through each gear under microcode, and a new item is taken only once
// the previous result has been emitted. A finished result sits in the rsp register
// while the next item is taken.
// Reset: synchronous; ratios, final drive and wheel factor clear to 0, held gear to 3.
// ----------------------------------------------------------------------------
// Gear estimator with shift rpm
// Matches measured rpm against expected rpm per gear, reports gear and shift rpms.
// ----------------------------------------------------------------------------
`default_nettype none

module gear_estimator_shift_rpm
   import gesr_pkg::*;
#(
   parameter int GEAR_COUNT = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // engine_rpm[13:0], vehicle_speed[21:14], zero pad
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // gear_found[2:0], upshift_rpm[18:3], downshift_rpm[34:19], zero pad
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CNT_W = (GEAR_COUNT > 1) ? $clog2(GEAR_COUNT) : 1;
   localparam logic [GEAR_W-1:0] GEAR_TOP = GEAR_W'(GEAR_COUNT);

   ctl_type          ctl;
   logic [CNT_W-1:0] cnt;
   logic             accept;
   logic             emit_ok;

   logic [RATIO_W-1:0]     ratio_ff [RATIO_COUNT];
   logic [RATIO_W-1:0]     ratio_in [RATIO_COUNT];
   logic [RATIO_W-1:0]     fd_ff, fd_in;
   logic [WRS_W-1:0]       wrs_ff, wrs_in;
   logic [RPM_W-1:0]       rpm_ff, rpm_in;
   logic [SPEED_W-1:0]     speed_ff, speed_in;
   logic [WHEEL_W-1:0]     w_ff, w_in;
   logic [DRIVE_W-1:0]     fw_ff, fw_in;
   logic [DRIVE_PCT_W-1:0] fw100_ff, fw100_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [GEAR_W-1:0]      found_ff, found_in;
   logic [GEAR_W-1:0]      held_ff, held_in;
   logic [SHIFT_W-1:0]     up_ff, up_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [GEAR_W-1:0]  ridx;
   logic               rok;
   logic               up_ok;
   logic               down_ok;
   logic [RATIO_W-1:0] ratio_rd;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [PROD_W-1:0]  prod_c;
   logic [HI_W-1:0]    prod_hi;
   logic               frac_nz;
   logic [LIM_W-1:0]   lo_lim;
   logic [LIM_W-1:0]   hi_lim;
   logic               match;
   logic [SHIFT_W-1:0] sat_rpm;

   gesr_seq #(
      .GEAR_COUNT (GEAR_COUNT),
      .CNT_W      (CNT_W)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .emit_ok (emit_ok),
      .ctl     (ctl),
      .cnt     (cnt)
   );

   assign req_tready = (ctl.jmp == JMP_WAIT);
   assign accept     = req_tvalid && req_tready;
   assign emit_ok    = ctl.emit && (!rsp_valid_ff || rsp_tready);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // operand select
   assign up_ok   = (held_ff >= 3'd1) && (held_ff < GEAR_TOP);
   assign down_ok = (held_ff >= 3'd2) && (held_ff <= GEAR_TOP);

   always_comb begin
      case (ctl.a_sel)
         ASEL_RATIO_UP: begin
            ridx = held_ff;
            rok  = up_ok;
         end
         ASEL_RATIO_DOWN: begin
            ridx = held_ff - 3'd2;
            rok  = down_ok;
         end
         default: begin
            ridx = GEAR_W'(cnt);
            rok  = 1'b1;
         end
      endcase
      ratio_rd = (rok && (ridx < GEAR_W'(RATIO_COUNT))) ? ratio_ff[ridx] : '0;
   end

   always_comb begin
      case (ctl.a_sel)
         ASEL_SPEED:      mul_a = MUL_A_W'(speed_ff);
         ASEL_FINAL:      mul_a = fd_ff;
         ASEL_SCALE:      mul_a = PCT_SCALE;
         ASEL_RATIO_LOOP: mul_a = ratio_rd;
         ASEL_RATIO_UP:   mul_a = ratio_rd;
         ASEL_RATIO_DOWN: mul_a = ratio_rd;
         default:         mul_a = '0;
      endcase
      case (ctl.b_sel)
         BSEL_WHEEL_CFG: mul_b = MUL_B_W'(wrs_ff);
         BSEL_WHEEL:     mul_b = MUL_B_W'(w_ff);
         BSEL_DRIVE:     mul_b = MUL_B_W'(fw_ff);
         BSEL_DRIVE_PCT: mul_b = MUL_B_W'(fw100_ff);
         default:        mul_b = '0;
      endcase
   end

   assign prod_c = PROD_W'(mul_a) * PROD_W'(mul_b);

   // window test: 87*rpm < 100*E/2^36 < 113*rpm
   assign prod_hi = prod_ff[PROD_W-1:FRAC_W];
   assign frac_nz = |prod_ff[FRAC_W-1:0];
   assign lo_lim  = LIM_W'(rpm_ff) * PCT_LO;
   assign hi_lim  = LIM_W'(rpm_ff) * PCT_HI;
   assign match   = ((prod_hi > HI_W'(lo_lim)) || ((prod_hi == HI_W'(lo_lim)) && frac_nz))
                    && (prod_hi < HI_W'(hi_lim));

   assign sat_rpm = (|prod_ff[PROD_W-1:FRAC_W+SHIFT_W]) ? {SHIFT_W{1'b1}}
                                                        : prod_ff[FRAC_W+SHIFT_W-1:FRAC_W];

   always_comb begin
      ratio_in = ratio_ff;
      fd_in    = fd_ff;
      wrs_in   = wrs_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RATIO_FIRST:  ratio_in[0] = csr_wdata[RATIO_W-1:0];
            CSR_RATIO_SECOND: ratio_in[1] = csr_wdata[RATIO_W-1:0];
            CSR_RATIO_THIRD:  ratio_in[2] = csr_wdata[RATIO_W-1:0];
            CSR_RATIO_FOURTH: ratio_in[3] = csr_wdata[RATIO_W-1:0];
            CSR_RATIO_FIFTH:  ratio_in[4] = csr_wdata[RATIO_W-1:0];
            CSR_RATIO_SIXTH:  ratio_in[5] = csr_wdata[RATIO_W-1:0];
            CSR_FINAL_DRIVE:  fd_in       = csr_wdata[RATIO_W-1:0];
            CSR_WHEEL:        wrs_in      = csr_wdata[WRS_W-1:0];
            default:          fd_in       = fd_ff;
         endcase
      end
   end

   always_comb begin
      rpm_in   = accept ? req_tdata[RPM_W-1:0] : rpm_ff;
      speed_in = accept ? req_tdata[RPM_W+SPEED_W-1:RPM_W] : speed_ff;
      w_in     = (ctl.dst == DST_WHEEL)     ? prod_c[WHEEL_W-1:0]     : w_ff;
      fw_in    = (ctl.dst == DST_DRIVE)     ? prod_c[DRIVE_W-1:0]     : fw_ff;
      fw100_in = (ctl.dst == DST_DRIVE_PCT) ? prod_c[DRIVE_PCT_W-1:0] : fw100_ff;
      prod_in  = (ctl.dst == DST_PROD)      ? prod_c                  : prod_ff;
      up_in    = ctl.up_ld ? sat_rpm : up_ff;

      found_in = found_ff;
      if (ctl.loop_clr) begin
         found_in = GEAR_NONE;
      end else if (ctl.test && match && (found_ff == GEAR_NONE)) begin
         found_in = GEAR_W'(cnt) + 3'd1;
      end

      held_in = held_ff;
      if (ctl.hold_upd && (found_ff != GEAR_NONE)) begin
         held_in = found_ff;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit_ok) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_W'({sat_rpm, up_ff, found_ff});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RATIO_COUNT; i++) begin
            ratio_ff[i] <= '0;
         end
         fd_ff        <= '0;
         wrs_ff       <= '0;
         held_ff      <= HELD_RESET;
         found_ff     <= GEAR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         ratio_ff     <= ratio_in;
         fd_ff        <= fd_in;
         wrs_ff       <= wrs_in;
         held_ff      <= held_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rpm_ff      <= rpm_in;
      speed_ff    <= speed_in;
      w_ff        <= w_in;
      fw_ff       <= fw_in;
      fw100_ff    <= fw100_in;
      prod_ff     <= prod_in;
      up_ff       <= up_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ----- sv/gesr_seq.sv -----
// ----------------------------------------------------------------------------
// Gear estimator sequencer
// Step counter, gear loop counter and control store lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module gesr_seq
   import gesr_pkg::*;
#(
   parameter int GEAR_COUNT = 6,
   parameter int CNT_W      = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             emit_ok,
   output ctl_type          ctl,
   output logic [CNT_W-1:0] cnt
);

   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GEAR_COUNT - 1);

   step_type         pc_ff, pc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      ctl    = ctl_rom(pc_ff);
      cnt    = cnt_ff;
      pc_in  = pc_ff;
      cnt_in = cnt_ff;
      if (ctl.loop_clr) begin
         cnt_in = '0;
      end else if (ctl.cnt_inc) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
      case (ctl.jmp)
         JMP_NEXT: pc_in = step_type'(pc_ff + 4'd1);
         JMP_WAIT: begin
            if (start) begin
               pc_in = step_type'(pc_ff + 4'd1);
            end
         end
         JMP_LOOP: begin
            if (cnt_ff != CNT_LAST) begin
               pc_in = ctl.target;
            end else begin
               pc_in = step_type'(pc_ff + 4'd1);
            end
         end
         JMP_EMIT: begin
            if (emit_ok) begin
               pc_in = ctl.target;
            end
         end
         default: pc_in = STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= STEP_IDLE;
         cnt_ff <= '0;
      end else begin
         pc_ff  <= pc_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/gesr_checker.sv -----
// ----------------------------------------------------------------------------
// Gear estimator port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gear_estimator_shift_rpm_assert.svh"

module gesr_checker
   import gesr_pkg::*;
#(
   parameter int GEAR_COUNT = 6
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   `GESR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `GESR_ASSERT_IMP(a_gear_range, clock, reset, rsp_tvalid, rsp_tdata[GEAR_W-1:0] <= GEAR_W'(GEAR_COUNT))
   `GESR_ASSERT_NXT(a_no_early_rsp, clock, reset, req_tvalid && req_tready, !$rose(rsp_tvalid))
   `GESR_ASSERT_IMP(a_ready_on_rsp, clock, reset, $rose(rsp_tvalid), req_tready)

endmodule

bind gear_estimator_shift_rpm gesr_checker #(.GEAR_COUNT(GEAR_COUNT)) u_checker (.*);

`default_nettype wire
